// ----- hdl/ilid_pkg.sv -----
`default_nettype none

package ilid_pkg;

    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 7;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_PUSH   = 3'd2,
        OP_POP    = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CM_HOLD       = 2'd0,
        CM_WRITE      = 2'd1,
        CM_SHIFT_UP   = 2'd2,
        CM_SHIFT_DOWN = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        status_t    status;
        logic       rd_en;
    } ilid_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ilid_cell.sv -----
`default_nettype none

module ilid_cell
    import ilid_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int POS_W      = 7,
    parameter int POSITION   = 0
)
(
    input  wire logic                  clk,
    input  wire cell_mode_t            mode,
    input  wire logic [POS_W-1:0]      pos,
    input  wire logic [WORD_WIDTH-1:0] wdata,
    input  wire logic [WORD_WIDTH-1:0] prev_word,
    input  wire logic [WORD_WIDTH-1:0] next_word,
    output logic [WORD_WIDTH-1:0]      word,
    output logic [WORD_WIDTH-1:0]      sel_word
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POSITION);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  at_pos;
    logic                  above_pos;

    assign at_pos    = (pos == MY_POS);
    assign above_pos = (MY_POS > pos);

    always_comb
    begin
        word_next = word_reg;
        case (mode)
            CM_WRITE:
            begin
                if (at_pos)
                    word_next = wdata;
            end
            CM_SHIFT_UP:
            begin
                // open a gap at pos: later cells take the word below them
                if (above_pos)
                    word_next = prev_word;
                else if (at_pos)
                    word_next = wdata;
            end
            CM_SHIFT_DOWN:
            begin
                // close the gap at pos: take the word from above
                if (above_pos || at_pos)
                    word_next = next_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = at_pos ? word_reg : '0;

endmodule

`default_nettype wire

// ----- hdl/ilid_ctrl.sv -----
`default_nettype none

module ilid_ctrl
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7,
    parameter int POS_W    = 7
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [2:0]         op,
    input  wire logic [INDEX_W-1:0] index,
    output ilid_cmd_t               cmd,
    output logic [POS_W-1:0]        pos,
    output logic [CNT_W-1:0]        fill,
    output logic [CNT_W-1:0]        fill_next
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic [CNT_W-1:0] fill_reg;
    logic [POS_W-1:0] idx_ext;
    logic [POS_W-1:0] fill_ext;
    logic             full;
    logic             empty;

    assign idx_ext  = POS_W'(index);
    assign fill_ext = POS_W'(fill_reg);
    assign full     = (fill_reg == CAP_CNT);
    assign empty    = (fill_reg == '0);

    always_comb
    begin
        cmd.mode   = CM_HOLD;
        cmd.status = ST_OK;
        cmd.rd_en  = 1'b0;
        pos        = idx_ext;
        fill_next  = fill_reg;
        if (accept)
        begin
            unique case (op)
                OP_GET:
                begin
                    if (idx_ext >= fill_ext)
                        cmd.status = ST_RANGE;
                    else
                        cmd.rd_en = 1'b1;
                end
                OP_SET:
                begin
                    if (idx_ext >= fill_ext)
                        cmd.status = ST_RANGE;
                    else
                        cmd.mode = CM_WRITE;
                end
                OP_PUSH:
                begin
                    pos = fill_ext;
                    if (full)
                        cmd.status = ST_FULL;
                    else
                    begin
                        cmd.mode  = CM_WRITE;
                        fill_next = fill_reg + ONE_CNT;
                    end
                end
                OP_POP:
                begin
                    pos = POS_W'(fill_reg - ONE_CNT);
                    if (empty)
                        cmd.status = ST_EMPTY;
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        fill_next = fill_reg - ONE_CNT;
                    end
                end
                OP_INSERT:
                begin
                    // range check wins over the full check
                    if (idx_ext > fill_ext)
                        cmd.status = ST_RANGE;
                    else if (full)
                        cmd.status = ST_FULL;
                    else
                    begin
                        cmd.mode  = CM_SHIFT_UP;
                        fill_next = fill_reg + ONE_CNT;
                    end
                end
                OP_DELETE:
                begin
                    if (idx_ext >= fill_ext)
                        cmd.status = ST_RANGE;
                    else
                    begin
                        cmd.mode  = CM_SHIFT_DOWN;
                        cmd.rd_en = 1'b1;
                        fill_next = fill_reg - ONE_CNT;
                    end
                end
                default:
                begin
                    cmd.mode = CM_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    assign fill = fill_reg;

endmodule

`default_nettype wire

// ----- hdl/indexed_list_insert_delete.sv -----
// Latency: the result appears on the cycle after the request, marked by done.
// Throughput: one request per cycle; each cell shifts from its neighbor in one step,
// so insert and delete take as long as get and set. busy stays low.
// Reset: rst_n clears the fill count and the done strobe; list words are not cleared
// and only positions below the length are ever read back.
`default_nettype none

module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          op,
    input  wire logic [INDEX_W-1:0]  index,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     done,
    output logic [1:0]               status,
    output logic [VALUE_W-1:0]       read_value,
    output logic [LENGTH_W-1:0]      length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic                  accept;
    ilid_cmd_t             cmd;
    logic [POS_W-1:0]      pos;
    logic [CNT_W-1:0]      fill;
    logic [CNT_W-1:0]      fill_next;
    logic [WORD_WIDTH-1:0] wdata;
    logic [WORD_WIDTH-1:0] words    [CAPACITY];
    logic [WORD_WIDTH-1:0] sel_words[CAPACITY];
    logic [WORD_WIDTH-1:0] rd_word;

    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [LENGTH_W-1:0]   length_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign wdata  = WORD_WIDTH'(value);

    ilid_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .POS_W    (POS_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .index     (index),
        .cmd       (cmd),
        .pos       (pos),
        .fill      (fill),
        .fill_next (fill_next)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] prev_word;
        logic [WORD_WIDTH-1:0] next_word;

        if (i == 0)
        begin : g_first
            assign prev_word = '0;
        end
        else
        begin : g_mid_lo
            assign prev_word = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_word = '0;
        end
        else
        begin : g_mid_hi
            assign next_word = words[i+1];
        end

        ilid_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .POS_W      (POS_W),
            .POSITION   (i)
        ) u_cell (
            .clk       (clk),
            .mode      (cmd.mode),
            .pos       (pos),
            .wdata     (wdata),
            .prev_word (prev_word),
            .next_word (next_word),
            .word      (words[i]),
            .sel_word  (sel_words[i])
        );
    end

    // only the addressed cell drives a nonzero word
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_word = rd_word | sel_words[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= cmd.status;
            read_value_reg <= cmd.rd_en ? VALUE_W'(rd_word) : '0;
            length_reg     <= LENGTH_W'(fill_next);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign length     = length_reg;

`ifndef SYNTHESIS
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("done missing after accepted request");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("done without a request");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_error_keeps_list: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_value == '0 && fill == $past(fill)))
        else $error("failed request changed the list or returned data");
`endif

endmodule

`default_nettype wire
